>>> src/tra_pkg.sv
package tra_pkg;

  localparam int unsigned CmdW  = 4;
  localparam int unsigned OpdW  = 16;
  localparam int unsigned DataW = 32;

  // Default word-address width of the data memory.
  localparam int unsigned AddrBits = 16;

  localparam logic [CmdW-1:0] OpLd   = 4'd0;
  localparam logic [CmdW-1:0] OpLdi  = 4'd1;
  localparam logic [CmdW-1:0] OpSt   = 4'd2;
  localparam logic [CmdW-1:0] OpAdd  = 4'd3;
  localparam logic [CmdW-1:0] OpAddi = 4'd4;
  localparam logic [CmdW-1:0] OpSub  = 4'd5;
  localparam logic [CmdW-1:0] OpSubi = 4'd6;
  localparam logic [CmdW-1:0] OpPut  = 4'd7;
  localparam logic [CmdW-1:0] OpJnz  = 4'd8;

endpackage

>>> src/tra_dmem.sv
module tra_dmem #(
  parameter int unsigned ADDR_BITS = tra_pkg::AddrBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [ADDR_BITS-1:0]      rd_addr_i,
  output logic [tra_pkg::DataW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [ADDR_BITS-1:0]      wr_addr_i,
  input  logic [tra_pkg::DataW-1:0] wr_data_i,
  output logic                      busy_o
);

  localparam int unsigned Words = 1 << ADDR_BITS;

  logic [tra_pkg::DataW-1:0] mem [Words];
  logic [tra_pkg::DataW-1:0] rd_data_q;
  logic                      busy_q, busy_d;
  logic [ADDR_BITS-1:0]      clr_cnt_q, clr_cnt_d;
  logic                      we;
  logic [ADDR_BITS-1:0]      waddr;
  logic [tra_pkg::DataW-1:0] wdata;

  // After reset a sweep writes zero to every word, one word per cycle.
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == {ADDR_BITS{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign we    = busy_q | wr_en_i;
  assign waddr = busy_q ? clr_cnt_q : wr_addr_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

  a_no_wr_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !wr_en_i) else $error("execute write during clearing sweep");

  a_no_rd_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rd_en_i) else $error("read issued during clearing sweep");

  a_clear_ends_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(clr_cnt_q) == {ADDR_BITS{1'b1}})
    else $error("clearing sweep ended early");

endmodule

>>> src/tra_core.sv
module tra_core #(
  parameter int unsigned ADDR_BITS = tra_pkg::AddrBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tra_pkg::CmdW-1:0]         command_i,
  input  logic                             reg_select_i,
  input  logic [tra_pkg::OpdW-1:0]         operand_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             jump_taken_o,
  output logic signed [tra_pkg::OpdW-1:0]  jump_offset_o,
  output logic                             print_valid_o,
  output logic                             print_reg_o,
  output logic [tra_pkg::DataW-1:0]        print_value_o,
  input  logic                             clr_busy_i,
  output logic                             rd_en_o,
  output logic [ADDR_BITS-1:0]             rd_addr_o,
  input  logic [tra_pkg::DataW-1:0]        rd_data_i,
  output logic                             wr_en_o,
  output logic [ADDR_BITS-1:0]             wr_addr_o,
  output logic [tra_pkg::DataW-1:0]        wr_data_o
);

  localparam int unsigned DW = tra_pkg::DataW;

  logic                       accept;
  logic                       s1_adv;
  logic                       s1_valid_q;
  logic [tra_pkg::CmdW-1:0]   s1_cmd_q;
  logic                       s1_sel_q;
  logic [tra_pkg::OpdW-1:0]   s1_opd_q;
  logic                       fwd_hit_q;
  logic [DW-1:0]              fwd_data_q;
  logic [DW-1:0]              reg_a_q, reg_a_d;
  logic [DW-1:0]              reg_b_q, reg_b_d;
  logic [DW-1:0]              target;
  logic [DW-1:0]              mem_word;
  logic [DW-1:0]              imm;
  logic [DW-1:0]              new_val;
  logic                       reg_we;
  logic                       taken_d, pvalid_d;
  logic                       out_valid_q;
  logic                       jump_taken_q, print_valid_q, print_reg_q;
  logic [tra_pkg::OpdW-1:0]   jump_offset_q;
  logic [DW-1:0]              print_value_q;

  // Stage 1 moves on whenever the output register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_i || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_en_o   = accept;
  assign rd_addr_o = operand_i[ADDR_BITS-1:0];

  assign target   = s1_sel_q ? reg_b_q : reg_a_q;
  assign mem_word = fwd_hit_q ? fwd_data_q : rd_data_i;
  assign imm      = {{(DW - tra_pkg::OpdW){1'b0}}, s1_opd_q};

  always_comb begin
    new_val  = target;
    reg_we   = 1'b0;
    wr_en_o  = 1'b0;
    taken_d  = 1'b0;
    pvalid_d = 1'b0;
    case (s1_cmd_q)
      tra_pkg::OpLd: begin
        new_val = mem_word;
        reg_we  = 1'b1;
      end
      tra_pkg::OpLdi: begin
        new_val = imm;
        reg_we  = 1'b1;
      end
      tra_pkg::OpSt: begin
        wr_en_o = s1_adv;
      end
      tra_pkg::OpAdd: begin
        new_val = target + mem_word;
        reg_we  = 1'b1;
      end
      tra_pkg::OpAddi: begin
        new_val = target + imm;
        reg_we  = 1'b1;
      end
      tra_pkg::OpSub: begin
        new_val = target - mem_word;
        reg_we  = 1'b1;
      end
      tra_pkg::OpSubi: begin
        new_val = target - imm;
        reg_we  = 1'b1;
      end
      tra_pkg::OpPut: begin
        pvalid_d = 1'b1;
      end
      tra_pkg::OpJnz: begin
        taken_d = (target != '0);
      end
      default: begin
      end
    endcase
  end

  assign wr_addr_o = s1_opd_q[ADDR_BITS-1:0];
  assign wr_data_o = target;

  always_comb begin
    reg_a_d = reg_a_q;
    reg_b_d = reg_b_q;
    if (s1_adv && reg_we) begin
      if (s1_sel_q) begin
        reg_b_d = new_val;
      end else begin
        reg_a_d = new_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      reg_a_q     <= '0;
      reg_b_q     <= '0;
    end else begin
      reg_a_q <= reg_a_d;
      reg_b_q <= reg_b_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A store retiring on the same edge as a new read is invisible to the
  // memory read, so its word is captured here and used instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= command_i;
      s1_sel_q   <= reg_select_i;
      s1_opd_q   <= operand_i;
      fwd_hit_q  <= wr_en_o && (wr_addr_o == operand_i[ADDR_BITS-1:0]);
      fwd_data_q <= wr_data_o;
    end
    if (s1_adv) begin
      jump_taken_q  <= taken_d;
      jump_offset_q <= taken_d ? s1_opd_q : '0;
      print_valid_q <= pvalid_d;
      print_reg_q   <= pvalid_d ? s1_sel_q : 1'b0;
      print_value_q <= pvalid_d ? target : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign jump_taken_o  = jump_taken_q;
  assign jump_offset_o = $signed(jump_offset_q);
  assign print_valid_o = print_valid_q;
  assign print_reg_o   = print_reg_q;
  assign print_value_o = print_value_q;

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q) else $error("stage 1 beat lost");

  a_write_on_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> s1_adv && s1_cmd_q == tra_pkg::OpSt)
    else $error("memory write without a retiring store");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(jump_taken_q && print_valid_q))
    else $error("result is both jump and print");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_i |-> !accept) else $error("beat accepted during clearing");

endmodule

>>> src/two_register_accumulator_execute.sv
// Execute stage of a small machine with two 32-bit registers, A and B, and a
// word-addressed data memory of 2^ADDR_BITS words.
// The input channel carries one decoded instruction per beat: command,
// reg_select and operand. The output channel returns exactly one result beat
// per instruction, in order: a jump flag with its signed offset and a print
// strobe with the register number and value. Both channels use valid and
// stall; a beat moves on an edge where valid is high and stall is low.
// The data memory read is issued on the accepting edge. In the following
// cycle the instruction executes against the register pair with the read
// word, and on the edge where it advances, which needs the output register
// to be empty or drained, its result enters the output register and a
// store is written back; the result is held there until it is taken.
// A store that retires on the same edge as a younger read is forwarded.
// Throughput is one instruction per cycle while the output is drained.
// When the receiver stalls, the result is held in the output register and
// one more instruction may still be taken into the execute stage.
// After reset both registers are zero and the memory is swept to zero, one
// word per cycle; input stall stays high until the sweep has finished.
module two_register_accumulator_execute #(
  parameter int unsigned ADDR_BITS = tra_pkg::AddrBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tra_pkg::CmdW-1:0]        command_i,
  input  logic                            reg_select_i,
  input  logic [tra_pkg::OpdW-1:0]        operand_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            jump_taken_o,
  output logic signed [tra_pkg::OpdW-1:0] jump_offset_o,
  output logic                            print_valid_o,
  output logic                            print_reg_o,
  output logic [tra_pkg::DataW-1:0]       print_value_o
);

  logic                       clr_busy;
  logic                       rd_en;
  logic [ADDR_BITS-1:0]       rd_addr;
  logic [tra_pkg::DataW-1:0]  rd_data;
  logic                       wr_en;
  logic [ADDR_BITS-1:0]       wr_addr;
  logic [tra_pkg::DataW-1:0]  wr_data;

  // Data memory with its post-reset clearing sweep.
  tra_dmem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (clr_busy)
  );

  // Register pair, execute stage, forwarding and output register.
  tra_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .reg_select_i  (reg_select_i),
    .operand_i     (operand_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .jump_taken_o  (jump_taken_o),
    .jump_offset_o (jump_offset_o),
    .print_valid_o (print_valid_o),
    .print_reg_o   (print_reg_o),
    .print_value_o (print_value_o),
    .clr_busy_i    (clr_busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

endmodule

>>> tb/two_register_accumulator_execute_tb.sv
module two_register_accumulator_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The data memory is checked at its full default size. After reset the
  // block sweeps every word to zero, one per cycle, with its input stalled, so
  // the idle limit has to cover that sweep several times over.
  localparam int unsigned MemAddrBits = tra_pkg::AddrBits;
  localparam int unsigned MemWords = 1 << MemAddrBits;
  localparam logic [tra_pkg::OpdW-1:0] AddrMask = tra_pkg::OpdW'(MemWords - 1);
  localparam int unsigned RandomItems = 950;
  localparam int unsigned IdleLimit = 4 * MemWords + 4096;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ClkHalf = 10;

  localparam logic RegA = 1'b0;
  localparam logic RegB = 1'b1;

  // Opcodes above JNZ are undefined; the block must ignore them and answer
  // with an all-zero result beat.
  localparam logic [tra_pkg::CmdW-1:0] OpUndefFirst = tra_pkg::OpJnz + 4'd1;
  localparam logic [tra_pkg::CmdW-1:0] OpUndefLast = '1;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  // One decoded instruction. drain_first holds the instruction back until
  // every earlier result beat has come out of the block.
  typedef struct packed {
    logic [tra_pkg::CmdW-1:0] command;
    logic                     reg_select;
    logic [tra_pkg::OpdW-1:0] operand;
    logic                     drain_first;
  } instr_t;

  typedef struct packed {
    logic                            jump_taken;
    logic signed [tra_pkg::OpdW-1:0] jump_offset;
    logic                            print_valid;
    logic                            print_reg;
    logic [tra_pkg::DataW-1:0]       print_value;
  } exec_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [tra_pkg::CmdW-1:0]        command_i = '0;
  logic                            reg_select_i = 1'b0;
  logic [tra_pkg::OpdW-1:0]        operand_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            jump_taken_o;
  logic signed [tra_pkg::OpdW-1:0] jump_offset_o;
  logic                            print_valid_o;
  logic                            print_reg_o;
  logic [tra_pkg::DataW-1:0]       print_value_o;

  // Instructions waiting to be driven, and results the block still owes.
  instr_t       instr_queue[$];
  exec_result_t results_due[$];

  // Shadow copy of the machine state: the two registers and the data memory.
  logic [tra_pkg::DataW-1:0] acc_a;
  logic [tra_pkg::DataW-1:0] acc_b;
  logic [tra_pkg::DataW-1:0] data_words[MemWords];

  int unsigned error_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned queued_cnt = 0;
  logic        beat_taken = 1'b0;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_mode_left = 0;
  logic [3:0]  stall_tick = '0;

  two_register_accumulator_execute #(
    .ADDR_BITS(MemAddrBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .reg_select_i (reg_select_i),
    .operand_i    (operand_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .jump_taken_o (jump_taken_o),
    .jump_offset_o(jump_offset_o),
    .print_valid_o(print_valid_o),
    .print_reg_o  (print_reg_o),
    .print_value_o(print_value_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Executes one instruction against the shadow state and returns the result
  // beat the block has to produce for it. Immediates are zero-extended and
  // memory addresses wrap inside the memory.
  function automatic exec_result_t execute_instr(instr_t ins);
    exec_result_t              res;
    logic [tra_pkg::DataW-1:0] target;
    logic [tra_pkg::DataW-1:0] mem_word;
    logic [tra_pkg::DataW-1:0] imm;
    int unsigned               addr;
    res = '0;
    target = ins.reg_select ? acc_b : acc_a;
    addr = int'(ins.operand & AddrMask);
    mem_word = data_words[addr];
    imm = tra_pkg::DataW'(ins.operand);
    case (ins.command)
      tra_pkg::OpLd:   target = mem_word;
      tra_pkg::OpLdi:  target = imm;
      tra_pkg::OpSt:   data_words[addr] = target;
      tra_pkg::OpAdd:  target = target + mem_word;
      tra_pkg::OpAddi: target = target + imm;
      tra_pkg::OpSub:  target = target - mem_word;
      tra_pkg::OpSubi: target = target - imm;
      tra_pkg::OpPut: begin
        res.print_valid = 1'b1;
        res.print_reg = ins.reg_select;
        res.print_value = target;
      end
      tra_pkg::OpJnz: begin
        if (target != '0) begin
          res.jump_taken = 1'b1;
          res.jump_offset = ins.operand;
        end
      end
      default: ;
    endcase
    if (ins.reg_select) begin
      acc_b = target;
    end else begin
      acc_a = target;
    end
    return res;
  endfunction

  function automatic void queue_instr(logic [tra_pkg::CmdW-1:0] cmd, logic sel,
                                      logic [tra_pkg::OpdW-1:0] opd,
                                      logic drain = 1'b0);
    instr_queue.insert(instr_queue.size(), '{cmd, sel, opd, drain});
    queued_cnt++;
  endfunction

  // Most addresses fall in a few words at either end of the memory so that
  // loads and arithmetic read back what earlier stores left there.
  function automatic logic [tra_pkg::OpdW-1:0] pick_addr();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return tra_pkg::OpdW'($urandom_range(0, 7));
    end else if (roll < 75) begin
      return AddrMask - tra_pkg::OpdW'($urandom_range(0, 7));
    end
    return tra_pkg::OpdW'($urandom);
  endfunction

  function automatic logic [tra_pkg::OpdW-1:0] pick_imm();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return tra_pkg::OpdW'($urandom_range(0, 15));
    end else if (roll < 60) begin
      return '1 - tra_pkg::OpdW'($urandom_range(0, 3));
    end
    return tra_pkg::OpdW'($urandom);
  endfunction

  // Receiver side. At each negedge the result stall is driven from a pattern
  // that changes its mode at random intervals: no stall at all, light or
  // heavy random stalls, or a fixed periodic pattern.
  always @(negedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(16, 160);
    end else begin
      stall_mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (stall_tick[2:0] > 3'd4);
    endcase
  end

  // Sender side. A new beat is presented only once the previous one has been
  // taken; a stalled beat is held unchanged. Beats come in bursts of random
  // length, now and then a long one, separated by random gaps that are
  // sometimes empty. An instruction marked drain_first waits until the
  // block has returned every outstanding result.
  always @(negedge clk_i) begin
    instr_t nxt;
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (instr_queue.size() != 0 &&
                   (!instr_queue[0].drain_first || results_due.size() == 0)) begin
        nxt = instr_queue.pop_front();
        command_i <= nxt.command;
        reg_select_i <= nxt.reg_select;
        operand_i <= nxt.operand;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor. On every rising edge an accepted result beat is compared with
  // the oldest expectation, and an accepted instruction beat is run through
  // the shadow machine to produce its own expectation. The result of an
  // instruction can never come out on the edge that accepts it, so the order
  // of the two steps does not matter.
  always @(posedge clk_i) begin
    exec_result_t want;
    beat_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat with no instruction outstanding");
          error_cnt++;
        end else begin
          want = results_due.pop_front();
          if (jump_taken_o !== want.jump_taken) begin
            $error("jump_taken: expected %0d, got %0d", want.jump_taken, jump_taken_o);
            error_cnt++;
          end
          if (jump_offset_o !== want.jump_offset) begin
            $error("jump_offset: expected %0d, got %0d", want.jump_offset, jump_offset_o);
            error_cnt++;
          end
          if (print_valid_o !== want.print_valid) begin
            $error("print_valid: expected %0d, got %0d", want.print_valid, print_valid_o);
            error_cnt++;
          end
          if (print_reg_o !== want.print_reg) begin
            $error("print_reg: expected %0d, got %0d", want.print_reg, print_reg_o);
            error_cnt++;
          end
          if (print_value_o !== want.print_value) begin
            $error("print_value: expected 0x%08h, got 0x%08h", want.print_value,
                   print_value_o);
            error_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        results_due.insert(results_due.size(),
                           execute_instr('{command_i, reg_select_i, operand_i, 1'b0}));
      end
    end
  end

  // Watchdog: a run where neither channel moves a beat for this long is hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("two_register_accumulator_execute_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned              kind;
    int unsigned              n;
    logic                     sel;
    logic [tra_pkg::OpdW-1:0] a;
    logic [tra_pkg::CmdW-1:0] cmd;
    logic                     drain_next;

    // Directed part: zero reads, operand extremes at both ends of memory,
    // wrap-around in both directions, both registers printed, jumps with the
    // most negative, most positive and minus-one offsets, a jump on a zero
    // register, and undefined opcodes that must leave the state alone.
    queue_instr(tra_pkg::OpLd, RegA, 16'h1234);
    queue_instr(tra_pkg::OpJnz, RegA, 16'h0005);
    queue_instr(tra_pkg::OpPut, RegB, 16'h0000);
    queue_instr(tra_pkg::OpLdi, RegA, 16'hffff);
    queue_instr(tra_pkg::OpSt, RegA, 16'hffff);
    queue_instr(tra_pkg::OpSt, RegA, 16'h0000);
    queue_instr(tra_pkg::OpLd, RegB, 16'hffff);
    queue_instr(tra_pkg::OpAdd, RegB, 16'h0000);
    queue_instr(tra_pkg::OpAddi, RegA, 16'hffff);
    queue_instr(tra_pkg::OpSub, RegA, 16'hffff);
    queue_instr(tra_pkg::OpSubi, RegB, 16'hffff);
    queue_instr(tra_pkg::OpLdi, RegA, 16'h0000);
    queue_instr(tra_pkg::OpSubi, RegA, 16'h0001);
    queue_instr(tra_pkg::OpSt, RegA, 16'h8000);
    queue_instr(tra_pkg::OpAdd, RegA, 16'h8000);
    queue_instr(tra_pkg::OpAddi, RegA, 16'h0002);
    queue_instr(tra_pkg::OpSub, RegA, 16'h8000);
    queue_instr(tra_pkg::OpPut, RegA, 16'h0000);
    queue_instr(tra_pkg::OpPut, RegB, 16'hffff);
    queue_instr(tra_pkg::OpJnz, RegA, 16'h8000);
    queue_instr(tra_pkg::OpJnz, RegB, 16'h7fff);
    queue_instr(tra_pkg::OpJnz, RegB, 16'hffff);
    queue_instr(OpUndefFirst, RegB, 16'hffff);
    queue_instr(OpUndefLast, RegA, 16'h5a5a);
    queue_instr(tra_pkg::OpPut, RegA, 16'h0000);

    // Random part, built from short program fragments: countdown loops of
    // decrements, prints and jumps, store and reload round trips through memory,
    // and stretches of arbitrary instructions including undefined ones. Now
    // and then the sender is made to wait for the block to drain completely.
    drain_next = 1'b1;
    n = queued_cnt + RandomItems;
    while (queued_cnt < n) begin
      kind = $urandom_range(0, 9);
      sel = 1'($urandom_range(0, 1));
      if (kind < 3) begin
        queue_instr(tra_pkg::OpLdi, sel, tra_pkg::OpdW'($urandom_range(1, 6)), drain_next);
        repeat ($urandom_range(1, 7)) begin
          queue_instr(tra_pkg::OpSubi, sel, 16'h0001);
          queue_instr(tra_pkg::OpPut, sel, pick_imm());
          queue_instr(tra_pkg::OpJnz, sel, tra_pkg::OpdW'($urandom));
        end
      end else if (kind < 6) begin
        a = pick_addr();
        queue_instr(tra_pkg::OpLdi, sel, pick_imm(), drain_next);
        queue_instr($urandom_range(0, 1) ? tra_pkg::OpAddi : tra_pkg::OpSubi, sel,
                    pick_imm());
        queue_instr(tra_pkg::OpSt, sel, a);
        queue_instr(tra_pkg::OpLd, ~sel, a);
        queue_instr($urandom_range(0, 1) ? tra_pkg::OpAdd : tra_pkg::OpSub, ~sel,
                    pick_addr());
        queue_instr(tra_pkg::OpPut, ~sel, pick_imm());
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 9) == 0) begin
            cmd = tra_pkg::CmdW'($urandom_range(OpUndefFirst, OpUndefLast));
          end else begin
            cmd = tra_pkg::CmdW'($urandom_range(tra_pkg::OpLd, tra_pkg::OpJnz));
          end
          queue_instr(cmd, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? pick_addr() : pick_imm(), drain_next);
          drain_next = 1'b0;
        end
      end
      drain_next = ($urandom_range(0, 99) < 3);
    end

    acc_a = '0;
    acc_b = '0;
    foreach (data_words[i]) begin
      data_words[i] = '0;
    end

    // Reset is held while the clock runs and released on a falling edge, away
    // from the edges where the block samples its inputs.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last instruction to be taken, then for every result, then
    // DrainCycles more cycles to catch any stray beat the block might still emit.
    while (instr_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("two_register_accumulator_execute_tb: PASS");
    end else begin
      $display("two_register_accumulator_execute_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> two_register_accumulator_execute.f
src/tra_pkg.sv
src/tra_dmem.sv
src/tra_core.sv
src/two_register_accumulator_execute.sv
tb/two_register_accumulator_execute_tb.sv
